// ===== rtl/dma_descriptor_ring_feeder_top_defines.svh =====
// Assertion helpers shared by the RTL of the descriptor ring feeder.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef DMA_DESCRIPTOR_RING_FEEDER_TOP_DEFINES_SVH
`define DMA_DESCRIPTOR_RING_FEEDER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DDRF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DDRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ddrf_pkg.sv =====
`timescale 1ns / 1ps
package ddrf_pkg;

  localparam int unsigned RING_SLOTS  = 32;
  localparam int unsigned CHUNK_BYTES = 4096;
  localparam int unsigned FIFO_BYTES  = 262144;

  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned LEVEL_W     = 19;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned TAG_W       = 4;
  localparam int unsigned PREBUF_W    = 5;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned CHUNK_SHIFT = $clog2(CHUNK_BYTES);
  localparam int unsigned MAX_IN_FLIGHT = RING_SLOTS - 1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned CMD_Q_DEPTH = 2;
  localparam int unsigned RES_Q_DEPTH = 2;

  localparam logic [PREBUF_W-1:0] PREBUF_RESET = PREBUF_W'(8);
  localparam logic [TAG_W-1:0]    TAG_RESET    = TAG_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREBUFFER  = 2'd0,
    CFG_TAG        = 2'd1,
    CFG_RING_BASE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_KICK     = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_STOP     = 2'd2
  } kind_e;

  typedef enum logic [0:0] {
    ENTRY_DESC  = 1'b0,
    ENTRY_START = 1'b1
  } entry_kind_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [LEVEL_W-1:0] fifo_level;
    logic               stream_running;
  } evt_t;

  typedef struct packed {
    entry_kind_e        entry_kind;
    logic [SLOT_W-1:0]  slot;
    logic [LEN_W-1:0]   length;
    logic [ADDR_W-1:0]  buffer_address;
    logic [LEVEL_W-1:0] fifo_after;
    logic [TAG_W-1:0]   start_tag;
    logic               last;
  } result_t;

  // Classified event handed from the front end to the sequencer.
  typedef struct packed {
    kind_e              op;
    logic [LEVEL_W-1:0] level;
    logic               running;
  } cmd_t;

  typedef struct packed {
    logic [PREBUF_W-1:0] prebuffer_slots;
    logic [TAG_W-1:0]    tag;
    logic [ADDR_W-1:0]   ring_base;
  } cfg_t;

endpackage

// ===== rtl/dma_descriptor_ring_feeder_top.sv =====
`timescale 1ns / 1ps
// DMA descriptor ring feeder. Each event (producer kick, buffer completion,
// stop/flush) is a transfer on the push/full side carrying the software FIFO
// level and, for a kick, the stream run bit. The block posts descriptors of
// at most CHUNK_BYTES into a ring of RING_SLOTS slots, keeping at most
// RING_SLOTS-1 slots in flight, and may follow a kick with a stream start
// command once enough slots are primed. Every descriptor or start command is
// one transfer on the empty/pop side, and the last one caused by an event has
// its last flag set; an event that causes nothing produces no transfer. A
// small front-end classifies events into a two-entry command queue, and a
// back-end sequencer executes them into a two-entry result queue, so the
// input side keeps accepting while results wait to be popped. The sequencer
// takes a command while idle, then posts one descriptor per cycle, at most
// RING_SLOTS-1 per event, except while the result queue is full, then decides
// on the start and issues it; it handles one event at a time. Configuration
// registers (prebuffer slots, stream tag, ring base) are written through
// cfg_we_i/cfg_idx_i/cfg_data_i and should only be changed while no event
// is pending.
module dma_descriptor_ring_feeder_top #(
  parameter int unsigned CMD_DEPTH = ddrf_pkg::CMD_Q_DEPTH,
  parameter int unsigned RES_DEPTH = ddrf_pkg::RES_Q_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  ddrf_pkg::evt_t                      evt_i,
  output logic                                empty,
  input  logic                                pop,
  output ddrf_pkg::result_t                   res_o,
  input  logic                                cfg_we_i,
  input  logic [ddrf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ddrf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ddrf_pkg::*;

  cfg_t    cfg_q;
  logic    cmd_valid;
  cmd_t    cmd_in;
  cmd_t    cmd_out;
  logic    cmd_full;
  logic    cmd_empty;
  logic    cmd_pop;
  logic    res_full;
  logic    res_push;
  result_t res_in;

  // Configuration registers; writes to an unused index are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prebuffer_slots <= PREBUF_RESET;
      cfg_q.tag             <= TAG_RESET;
      cfg_q.ring_base       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PREBUFFER:  cfg_q.prebuffer_slots <= cfg_data_i[PREBUF_W-1:0];
        CFG_TAG:        cfg_q.tag             <= cfg_data_i[TAG_W-1:0];
        CFG_RING_BASE:  cfg_q.ring_base       <= cfg_data_i[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // An event transfer happens whenever the command queue has room; events
  // of the unused kind are dropped by the front end.
  assign full = cmd_full;

  ddrf_front u_front (
    .evt_i      (evt_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd_in)
  );

  ddrf_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && cmd_valid),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  ddrf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  ddrf_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_o),
    .empty_o(empty)
  );

endmodule

// ===== rtl/ddrf_fifo.sv =====
`timescale 1ns / 1ps
module ddrf_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/ddrf_front.sv =====
`timescale 1ns / 1ps
module ddrf_front (
  input  ddrf_pkg::evt_t evt_i,
  output logic           cmd_valid_o,
  output ddrf_pkg::cmd_t cmd_o
);
  import ddrf_pkg::*;

  logic [LEVEL_W-1:0] level_sat;

  // Levels above the FIFO size are clamped to the FIFO size.
  assign level_sat = (evt_i.fifo_level > LEVEL_W'(FIFO_BYTES)) ?
                     LEVEL_W'(FIFO_BYTES) : evt_i.fifo_level;

  always_comb begin
    cmd_o.level   = level_sat;
    cmd_o.running = evt_i.stream_running;
    case (evt_i.kind)
      KIND_KICK: begin
        cmd_valid_o = 1'b1;
        cmd_o.op    = KIND_KICK;
      end
      KIND_COMPLETE: begin
        cmd_valid_o = 1'b1;
        cmd_o.op    = KIND_COMPLETE;
      end
      KIND_STOP: begin
        cmd_valid_o = 1'b1;
        cmd_o.op    = KIND_STOP;
      end
      default: begin
        // The unused kind code is taken and dropped here.
        cmd_valid_o = 1'b0;
        cmd_o.op    = KIND_KICK;
      end
    endcase
  end

endmodule

// ===== rtl/ddrf_back.sv =====
`timescale 1ns / 1ps
`include "dma_descriptor_ring_feeder_top_defines.svh"
module ddrf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ddrf_pkg::cfg_t    cfg_i,
  input  logic              cmd_empty_i,
  input  ddrf_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output ddrf_pkg::result_t res_o
);
  import ddrf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_POST  = 3'b010,
    ST_START = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [COUNT_W-1:0]  outstanding_q, outstanding_d;
  logic [SLOT_W-1:0]   next_slot_q, next_slot_d;
  logic                stream_on_q, stream_on_d;
  logic                check_start_q, check_start_d;
  logic [LEVEL_W-1:0]  level_q, level_d;

  logic [LEN_W-1:0]    len;
  logic [LEVEL_W-1:0]  level_after;
  logic [COUNT_W-1:0]  flight_after;
  logic [PREBUF_W-1:0] thr;
  logic                can_post;
  logic                more_after;
  logic                desc_last;
  logic [ADDR_W-1:0]   desc_addr;
  logic                push_start;
  logic                push_desc;

  function automatic logic start_due(logic [COUNT_W-1:0]  fl,
                                     logic [LEVEL_W-1:0]  lv,
                                     logic [PREBUF_W-1:0] th);
    return (fl >= COUNT_W'(th)) || ((fl != '0) && (lv == '0));
  endfunction

  assign len = (level_q > LEVEL_W'(CHUNK_BYTES)) ? LEN_W'(CHUNK_BYTES) :
               LEN_W'(level_q);
  assign level_after  = level_q - LEVEL_W'(len);
  assign flight_after = outstanding_q + COUNT_W'(1);
  assign thr          = (cfg_i.prebuffer_slots == '0) ? PREBUF_W'(1) :
                        cfg_i.prebuffer_slots;
  assign can_post     = (outstanding_q < COUNT_W'(MAX_IN_FLIGHT)) && (level_q != '0);
  assign more_after   = (flight_after < COUNT_W'(MAX_IN_FLIGHT)) && (level_after != '0);
  // A descriptor closes the event when nothing more is posted and no start follows.
  assign desc_last    = !more_after &&
                        !(check_start_q && start_due(flight_after, level_after, thr));
  assign desc_addr    = cfg_i.ring_base + (ADDR_W'(next_slot_q) << CHUNK_SHIFT);

  assign cmd_pop_o  = (state_q == ST_IDLE) && !cmd_empty_i;
  assign res_push_o = !res_full_i &&
                      (((state_q == ST_POST) && can_post) || (state_q == ST_START));
  assign push_start = res_push_o && (res_o.entry_kind == ENTRY_START);
  assign push_desc  = res_push_o && (res_o.entry_kind == ENTRY_DESC);

  always_comb begin
    if (state_q == ST_START) begin
      res_o.entry_kind     = ENTRY_START;
      res_o.slot           = '0;
      res_o.length         = '0;
      res_o.buffer_address = '0;
      res_o.fifo_after     = level_q;
      res_o.start_tag      = cfg_i.tag;
      res_o.last           = 1'b1;
    end else begin
      res_o.entry_kind     = ENTRY_DESC;
      res_o.slot           = next_slot_q;
      res_o.length         = len;
      res_o.buffer_address = desc_addr;
      res_o.fifo_after     = level_after;
      res_o.start_tag      = '0;
      res_o.last           = desc_last;
    end
  end

  always_comb begin
    state_d       = state_q;
    outstanding_d = outstanding_q;
    next_slot_d   = next_slot_q;
    stream_on_d   = stream_on_q;
    check_start_d = check_start_q;
    level_d       = level_q;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.op)
            KIND_KICK: begin
              if (!(stream_on_q && cmd_i.running)) begin
                // A halted stream resyncs: nothing is left in flight.
                if (stream_on_q) begin
                  outstanding_d = '0;
                  stream_on_d   = 1'b0;
                end
                level_d       = cmd_i.level;
                check_start_d = 1'b1;
                state_d       = ST_POST;
              end
            end
            KIND_COMPLETE: begin
              outstanding_d = outstanding_q - COUNT_W'(1);
              level_d       = cmd_i.level;
              check_start_d = 1'b0;
              state_d       = ST_POST;
            end
            KIND_STOP: begin
              outstanding_d = '0;
              next_slot_d   = '0;
              stream_on_d   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_POST: begin
        if (can_post) begin
          if (!res_full_i) begin
            outstanding_d = flight_after;
            level_d       = level_after;
            next_slot_d   = (next_slot_q == SLOT_W'(RING_SLOTS - 1)) ? '0 :
                            next_slot_q + SLOT_W'(1);
          end
        end else if (check_start_q && start_due(outstanding_q, level_q, thr)) begin
          state_d = ST_START;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_START: begin
        if (!res_full_i) begin
          stream_on_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      outstanding_q <= '0;
      next_slot_q   <= '0;
      stream_on_q   <= 1'b0;
      check_start_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      outstanding_q <= outstanding_d;
      next_slot_q   <= next_slot_d;
      stream_on_q   <= stream_on_d;
      check_start_q <= check_start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  `DDRF_ASSERT_IMPL(a_push_has_room, res_push_o, !res_full_i, "result pushed into a full queue")
  `DDRF_ASSERT_IMPL(a_start_only_when_off, state_q == ST_START, !stream_on_q, "start while on")
  `DDRF_ASSERT_NEXT(a_start_sets_on, push_start, stream_on_q, "start did not set stream on")
  `DDRF_ASSERT_IMPL(a_desc_len_ok, push_desc, len != '0 && len <= LEN_W'(CHUNK_BYTES), "bad len")

endmodule
